>>> rtl/fpct_pkg.sv
// shared types, code table and character lookup function of the prefix code transcoder
`default_nettype none
package fpct_pkg;

	localparam int MAX_CODE_LEN = 8;
	localparam int NUM_SYMBOLS  = 32;
	localparam int BUF_W        = 12;
	localparam int CNT_W        = 4;
	localparam int SYM_W        = 5;
	localparam int LEN_W        = 4;
	localparam int MAX_PER_ITEM = 4;

	typedef logic [6:0]       char_t;
	typedef logic [BUF_W-1:0] buf_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic [LEN_W-1:0]        len;
		logic [MAX_CODE_LEN-1:0] bits;
		char_t                   ch;
	} codeword_t;

	// result of one codeword lookup at the head of the buffer
	typedef struct packed {
		logic             hit;
		logic [LEN_W-1:0] len;
		char_t            ch;
	} dec_res_t;

	localparam codeword_t CODE_TABLE [NUM_SYMBOLS] = '{
		'{4'd3, 8'h05, 7'h20}, '{4'd6, 8'h00, 7'h27}, '{4'd6, 8'h03, 7'h2C},
		'{4'd8, 8'h91, 7'h2D}, '{4'd6, 8'h11, 7'h2E}, '{4'd6, 8'h01, 7'h3F},
		'{4'd6, 8'h25, 7'h41}, '{4'd8, 8'h9A, 7'h42}, '{4'd4, 8'h05, 7'h43},
		'{4'd4, 8'h01, 7'h44}, '{4'd3, 8'h06, 7'h45}, '{4'd5, 8'h09, 7'h46},
		'{4'd8, 8'h9B, 7'h47}, '{4'd6, 8'h10, 7'h48}, '{4'd4, 8'h07, 7'h49},
		'{4'd8, 8'h98, 7'h4A}, '{4'd4, 8'h06, 7'h4B}, '{4'd5, 8'h04, 7'h4C},
		'{4'd8, 8'h99, 7'h4D}, '{4'd8, 8'h9E, 7'h4E}, '{4'd5, 8'h05, 7'h4F},
		'{4'd3, 8'h07, 7'h50}, '{4'd8, 8'h9F, 7'h51}, '{4'd4, 8'h08, 7'h52},
		'{4'd5, 8'h06, 7'h53}, '{4'd5, 8'h07, 7'h54}, '{4'd8, 8'h9C, 7'h55},
		'{4'd8, 8'h9D, 7'h56}, '{4'd6, 8'h02, 7'h57}, '{4'd8, 8'h92, 7'h58},
		'{4'd8, 8'h93, 7'h59}, '{4'd8, 8'h90, 7'h5A}
	};

	localparam char_t CH_A     = 7'h41;
	localparam char_t CH_Z     = 7'h5A;
	localparam char_t CH_SPACE = 7'h20;
	localparam char_t CH_DOT   = 7'h2E;
	localparam char_t CH_COMMA = 7'h2C;
	localparam char_t CH_HYPH  = 7'h2D;
	localparam char_t CH_APOS  = 7'h27;
	localparam char_t CH_QUES  = 7'h3F;

	// returns {mapped, 5-bit symbol}
	function automatic logic [SYM_W:0] char_code(input char_t c);
		char_t d;
		d = c - CH_A;
		if (c >= CH_A && c <= CH_Z)
			return {1'b1, d[SYM_W-1:0]};
		case (c)
			CH_SPACE: return {1'b1, 5'd26};
			CH_DOT:   return {1'b1, 5'd27};
			CH_COMMA: return {1'b1, 5'd28};
			CH_HYPH:  return {1'b1, 5'd29};
			CH_APOS:  return {1'b1, 5'd30};
			CH_QUES:  return {1'b1, 5'd31};
			default:  return '0;
		endcase
	endfunction

endpackage
`default_nettype wire

>>> rtl/fpct_decode_unit.sv
// shared lookup unit: finds the codeword at the head of the bit buffer
`default_nettype none
module fpct_decode_unit
	import fpct_pkg::*;
(
	input  wire buf_t     bits,
	input  wire cnt_t     count,
	output dec_res_t      res
);

	buf_t                    aligned;
	logic [MAX_CODE_LEN-1:0] window;

	always_comb begin
		// left-align the valid bits, oldest bit on top
		aligned = bits << (CNT_W'(BUF_W) - count);
		window  = aligned[BUF_W-1 -: MAX_CODE_LEN];
	end

	// the code is prefix free, so at most one entry matches
	always_comb begin
		res = '0;
		for (int k = 0; k < NUM_SYMBOLS; k++) begin
			if (CNT_W'(CODE_TABLE[k].len) <= count &&
			    (window >> (LEN_W'(MAX_CODE_LEN) - CODE_TABLE[k].len)) ==
			    CODE_TABLE[k].bits) begin
				res.hit = 1'b1;
				res.len = CODE_TABLE[k].len;
				res.ch  = CODE_TABLE[k].ch;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/fixed_prefix_code_transcoder.sv
// top level: character stream to prefix-code decoded character stream
// an item is taken while the sequencer is idle, then one codeword is decoded per cycle
// by the single lookup unit while the output is not stalled; the end marker gets a state
// of its own when characters came before it
// input is not ready until the item's last result sits in the output register
// reset (arst_n low) clears the bit buffer, the sequencer and the output register
`default_nettype none
module fixed_prefix_code_transcoder
	import fpct_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire  [7:0] s_axis_tdata,   // [6:0] in_char, [7] zero
	input  wire        s_axis_tlast,   // end_of_line
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [6:0] out_char, [7] last
	output logic       m_axis_tuser,   // char_valid
	output logic       m_axis_tlast    // line_end
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DECODE = 2'd1;
	localparam logic [1:0] ST_MARK   = 2'd2;

	logic [1:0] state_q;
	buf_t       buf_q;
	cnt_t       cnt_q;
	logic       eol_q;
	logic [2:0] ndec_q;
	logic       pend_q;
	char_t      pend_ch_q;

	logic       out_valid_q;
	char_t      out_ch_q;
	logic       out_cv_q;
	logic       out_le_q;
	logic       out_last_q;

	dec_res_t         dec;
	logic [SYM_W:0]   sym;
	logic             out_free;
	logic             out_load;
	logic             take;
	cnt_t             cnt_left;

	fpct_decode_unit u_dec (
		.bits  (buf_q),
		.count (cnt_q),
		.res   (dec)
	);

	assign sym           = char_code(s_axis_tdata[6:0]);
	assign s_axis_tready = (state_q == ST_IDLE);
	assign out_free      = !out_valid_q || m_axis_tready;
	assign take          = dec.hit && (ndec_q < 3'(MAX_PER_ITEM));
	assign cnt_left      = cnt_q - CNT_W'(dec.len);
	// a new beat enters the output register this cycle
	assign out_load      = out_free &&
		(((state_q == ST_DECODE) && (pend_q || (!take && eol_q))) ||
		 (state_q == ST_MARK));

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_last_q, out_ch_q};
	assign m_axis_tuser  = out_cv_q;
	assign m_axis_tlast  = out_le_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			buf_q       <= '0;
			cnt_q       <= '0;
			eol_q       <= 1'b0;
			ndec_q      <= '0;
			pend_q      <= 1'b0;
			pend_ch_q   <= '0;
			out_valid_q <= 1'b0;
			out_ch_q    <= '0;
			out_cv_q    <= 1'b0;
			out_le_q    <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						if (sym[SYM_W] && cnt_q <= CNT_W'(BUF_W - SYM_W)) begin
							buf_q <= {buf_q[BUF_W-SYM_W-1:0], sym[SYM_W-1:0]};
							cnt_q <= cnt_q + CNT_W'(SYM_W);
						end
						eol_q   <= s_axis_tlast;
						ndec_q  <= '0;
						pend_q  <= 1'b0;
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					if (out_free) begin
						if (take) begin
							// the held char is not last: another one follows
							if (pend_q) begin
								out_ch_q    <= pend_ch_q;
								out_cv_q    <= 1'b1;
								out_le_q    <= 1'b0;
								out_last_q  <= 1'b0;
							end
							pend_q    <= 1'b1;
							pend_ch_q <= dec.ch;
							cnt_q     <= cnt_left;
							buf_q     <= buf_q & ~(buf_t'('1) << cnt_left);
							ndec_q    <= ndec_q + 3'd1;
						end else if (pend_q) begin
							out_ch_q    <= pend_ch_q;
							out_cv_q    <= 1'b1;
							out_le_q    <= 1'b0;
							out_last_q  <= !eol_q;
							pend_q      <= 1'b0;
							state_q     <= eol_q ? ST_MARK : ST_IDLE;
						end else if (eol_q) begin
							out_ch_q    <= '0;
							out_cv_q    <= 1'b0;
							out_le_q    <= 1'b1;
							out_last_q  <= 1'b1;
							buf_q       <= '0;
							cnt_q       <= '0;
							state_q     <= ST_IDLE;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_MARK: begin
					if (out_free) begin
						out_ch_q    <= '0;
						out_cv_q    <= 1'b0;
						out_le_q    <= 1'b1;
						out_last_q  <= 1'b1;
						buf_q       <= '0;
						cnt_q       <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/fpct_checker.sv
// port-level checker for the transcoder, bound to the top level
`default_nettype none
module fpct_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       s_axis_tvalid,
	input wire       s_axis_tready,
	input wire [7:0] s_axis_tdata,
	input wire       s_axis_tlast,
	input wire       m_axis_tvalid,
	input wire       m_axis_tready,
	input wire [7:0] m_axis_tdata,
	input wire       m_axis_tuser,
	input wire       m_axis_tlast
);

	// a line-end beat carries no character and closes the item's results
	a_mark_form: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |->
		(!m_axis_tuser && m_axis_tdata[7] && m_axis_tdata[6:0] == 7'd0))
		else $error("line-end beat malformed");

	// every beat is either a character or the line end, never both or neither
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser != m_axis_tlast))
		else $error("beat kind inconsistent");

	// after accepting an input beat the block is not ready in the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted back to back");

	// a stalled output beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
		 $stable(m_axis_tlast)))
		else $error("output beat changed while stalled");

endmodule

bind fixed_prefix_code_transcoder fpct_checker u_fpct_checker (.*);
`default_nettype wire

>>> dv/fpct_decode_checker.sv
// checker: predicts the decoded character beats of the transcoder and compares them
module fpct_decode_checker
	import fpct_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_axis_tvalid,
	input  wire        s_axis_tready,
	input  wire  [7:0] s_axis_tdata,   // [6:0] in_char, [7] zero
	input  wire        s_axis_tlast,   // end_of_line
	input  wire        m_axis_tvalid,
	input  wire        m_axis_tready,
	input  wire  [7:0] m_axis_tdata,   // [6:0] out_char, [7] last
	input  wire        m_axis_tuser,   // char_valid
	input  wire        m_axis_tlast,   // line_end
	output int         errors,
	output int         pending,
	output int         beats_checked
);

	typedef struct packed {
		char_t ch;
		logic  char_valid;
		logic  line_end;
		logic  last;
	} dec_beat_t;

	dec_beat_t  decoded_q [$];
	logic [11:0] pend_bits;
	logic [3:0]  pend_cnt;

	// 5-bit symbol of a character, 0 when the character carries no bits
	function automatic logic symbol_of(input char_t c, output logic [4:0] s);
		symbol_of = 1'b1;
		s = '0;
		if (c >= CH_A && c <= CH_Z)
			s = 5'(c - CH_A);
		else begin
			case (c)
				CH_SPACE: s = 5'd26;
				CH_DOT:   s = 5'd27;
				CH_COMMA: s = 5'd28;
				CH_HYPH:  s = 5'd29;
				CH_APOS:  s = 5'd30;
				CH_QUES:  s = 5'd31;
				default:  symbol_of = 1'b0;
			endcase
		end
	endfunction

	function automatic logic codeword_char(input logic [3:0] len, input logic [7:0] bits,
		output char_t ch);
		logic [7:0] c8;
		codeword_char = 1'b1;
		c8 = 8'h00;
		case ({len, bits})
			{4'd3, 8'h05}: c8 = " ";
			{4'd6, 8'h00}: c8 = "'";
			{4'd6, 8'h03}: c8 = ",";
			{4'd8, 8'h91}: c8 = "-";
			{4'd6, 8'h11}: c8 = ".";
			{4'd6, 8'h01}: c8 = "?";
			{4'd6, 8'h25}: c8 = "A";
			{4'd8, 8'h9A}: c8 = "B";
			{4'd4, 8'h05}: c8 = "C";
			{4'd4, 8'h01}: c8 = "D";
			{4'd3, 8'h06}: c8 = "E";
			{4'd5, 8'h09}: c8 = "F";
			{4'd8, 8'h9B}: c8 = "G";
			{4'd6, 8'h10}: c8 = "H";
			{4'd4, 8'h07}: c8 = "I";
			{4'd8, 8'h98}: c8 = "J";
			{4'd4, 8'h06}: c8 = "K";
			{4'd5, 8'h04}: c8 = "L";
			{4'd8, 8'h99}: c8 = "M";
			{4'd8, 8'h9E}: c8 = "N";
			{4'd5, 8'h05}: c8 = "O";
			{4'd3, 8'h07}: c8 = "P";
			{4'd8, 8'h9F}: c8 = "Q";
			{4'd4, 8'h08}: c8 = "R";
			{4'd5, 8'h06}: c8 = "S";
			{4'd5, 8'h07}: c8 = "T";
			{4'd8, 8'h9C}: c8 = "U";
			{4'd8, 8'h9D}: c8 = "V";
			{4'd6, 8'h02}: c8 = "W";
			{4'd8, 8'h92}: c8 = "X";
			{4'd8, 8'h93}: c8 = "Y";
			{4'd8, 8'h90}: c8 = "Z";
			default:       codeword_char = 1'b0;
		endcase
		ch = c8[6:0];
	endfunction

	// append the symbol bits, peel off finished codewords, close the line if asked
	task automatic predict_decode(input char_t c, input logic eol);
		logic [4:0] sym;
		logic       hit;
		logic [7:0] head;
		char_t      ch;
		dec_beat_t  beats [5];
		int         n;
		int         len;
		n = 0;
		if (symbol_of(c, sym) && int'(pend_cnt) + 5 <= 12) begin
			pend_bits = {pend_bits[6:0], sym};
			pend_cnt = pend_cnt + 4'd5;
		end
		hit = 1'b1;
		while (n < 4 && hit) begin
			hit = 1'b0;
			for (len = 3; len <= MAX_CODE_LEN && !hit && len <= int'(pend_cnt); len++) begin
				head = 8'((pend_bits >> (int'(pend_cnt) - len)) & ((12'd1 << len) - 12'd1));
				if (codeword_char(4'(len), head, ch)) begin
					hit = 1'b1;
					pend_cnt = pend_cnt - 4'(len);
					pend_bits = pend_bits & ((12'd1 << pend_cnt) - 12'd1);
					beats[n] = '{ch: ch, char_valid: 1'b1, line_end: 1'b0, last: 1'b0};
					n++;
				end
			end
		end
		if (eol) begin
			// leftover partial bits are dropped, no retry
			beats[n] = '{ch: '0, char_valid: 1'b0, line_end: 1'b1, last: 1'b0};
			n++;
			pend_bits = '0;
			pend_cnt = '0;
		end
		if (n > 0)
			beats[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			decoded_q.push_back(beats[i]);
	endtask

	function automatic void check_field(input string name, input int exp, input int act);
		if (exp != act) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dec_beat_t want;
		if (!arst_n) begin
			pend_bits = '0;
			pend_cnt = '0;
			decoded_q.delete();
			errors = 0;
			beats_checked = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (decoded_q.size() == 0) begin
					$display("%0t: unexpected beat, expected none, got data %h user %b last %b",
						$time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
					errors++;
				end else begin
					want = decoded_q.pop_front();
					check_field("out_char", want.ch, m_axis_tdata[6:0]);
					check_field("char_valid", want.char_valid, m_axis_tuser);
					check_field("line_end", want.line_end, m_axis_tlast);
					check_field("last", want.last, m_axis_tdata[7]);
					beats_checked++;
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_decode(s_axis_tdata[6:0], s_axis_tlast);
		end
		pending = decoded_q.size();
	end

endmodule

>>> dv/fixed_prefix_code_transcoder_tb.sv
// testbench top: clock, reset, character stimulus, output backpressure and verdict
module fixed_prefix_code_transcoder_tb;
	import fpct_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 85;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;   // [6:0] in_char, [7] zero
	logic       s_axis_tlast = 1'b0;    // end_of_line
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;           // [6:0] out_char, [7] last
	logic       m_axis_tuser;           // char_valid
	logic       m_axis_tlast;           // line_end

	int   errors;
	int   pending;
	int   beats_checked;
	int   chars_sent = 0;
	int   lines_sent = 0;
	int   idle_cycles = 0;
	logic no_idle = 1'b0;

	always #1 clk = ~clk;

	fixed_prefix_code_transcoder DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	fpct_decode_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.errors        (errors),
		.pending       (pending),
		.beats_checked (beats_checked)
	);

	function automatic char_t symbol_char(input int s);
		if (s < 26)
			return 7'(CH_A + s);
		case (s)
			26:      return CH_SPACE;
			27:      return CH_DOT;
			28:      return CH_COMMA;
			29:      return CH_HYPH;
			30:      return CH_APOS;
			default: return CH_QUES;
		endcase
	endfunction

	// entered and left at a falling edge
	task automatic send_char(input char_t c, input logic eol);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {1'b0, c};
		s_axis_tlast = eol;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		chars_sent++;
		if (eol)
			lines_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s, input logic eol_at_end);
		byte b;
		for (int i = 0; i < s.len(); i++) begin
			b = s[i];
			send_char(b[6:0], eol_at_end && i == s.len() - 1);
		end
	endtask

	task automatic drain_results();
		s_axis_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// output side: random stall per beat, sometimes always ready
	initial begin
		int stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				m_axis_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready = 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: watchdog, no beat accepted for %0d cycles, %0d results outstanding",
				$time, idle_cycles, pending);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		char_t c;
		logic  eol;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, leftover bits, unmapped chars, every punctuation mark
		send_char(7'h00, 1'b0);
		send_text("B", 1'b0);
		send_char(7'h7F, 1'b1);
		send_text("AZ .,-'?", 1'b1);
		send_text("PACK", 1'b1);
		send_char(7'h40, 1'b0);
		send_text("X", 1'b0);
		send_char(7'h5B, 1'b1);
		drain_results();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if ($urandom_range(0, 19) == 0)
				no_idle = !no_idle;
			if (i % 30 == 29)
				drain_results();
			if ($urandom_range(0, 99) < 85)
				c = symbol_char($urandom_range(0, 31));
			else
				c = 7'($urandom_range(0, 127));
			eol = ($urandom_range(0, 7) == 0);
			send_char(c, eol);
		end

		drain_results();
		repeat (16) @(negedge clk);
		$display("covered %0d characters in %0d closed lines, %0d output beats checked",
			chars_sent, lines_sent, beats_checked);
		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> fixed_prefix_code_transcoder.f
rtl/fpct_pkg.sv
rtl/fpct_decode_unit.sv
rtl/fixed_prefix_code_transcoder.sv
rtl/fpct_checker.sv
dv/fpct_decode_checker.sv
dv/fixed_prefix_code_transcoder_tb.sv
